@@ hw/rtl/incremental_pid_controller_top_macros.svh @@
// Assertion macros shared by the velocity-form PID controller RTL.
// Needs nothing; SYNTH empties every macro body.
`ifndef INCREMENTAL_PID_CONTROLLER_TOP_MACROS_SVH
`define INCREMENTAL_PID_CONTROLLER_TOP_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/ipid_pkg.sv @@
// Types, register map and constants of the velocity-form PID controller.
// No dependencies.
package ipid_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int ERR_W         = 17;
  localparam int DIFF_W        = 19;
  localparam int PROD_W        = 35;
  localparam int SUM_W         = 37;
  localparam int LIM_INC_UNITS = 100;
  localparam int LIM_POS_UNITS = 75;
  localparam int ADDR_W        = 4;

  localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
  localparam logic [1:0] REG_DERIV_GAIN = 2'd2;
  localparam logic [1:0] REG_REVERSE    = 2'd3;

  localparam logic signed [15:0] PROP_GAIN_RST  = 16'sd19200;
  localparam logic signed [15:0] INTEG_GAIN_RST = 16'sd2304;
  localparam logic signed [15:0] DERIV_GAIN_RST = -16'sd25600;

  localparam logic [1:0] STEPS_FIRST  = 2'd0;
  localparam logic [1:0] STEPS_SECOND = 2'd1;
  localparam logic [1:0] STEPS_LATER  = 2'd2;

  typedef struct packed {
    logic signed [15:0] setpoint;
    logic signed [15:0] measured;
    logic signed [15:0] manual_position;
    logic               auto_mode;
    logic               clear_history;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic signed [15:0] step_change;
  } out_rsp_t;

  typedef struct packed {
    logic signed [15:0] prop_gain;
    logic signed [15:0] integ_gain;
    logic signed [15:0] deriv_gain;
    logic               reverse_action;
  } cfg_t;

endpackage

@@ hw/rtl/ipid_regs.sv @@
// APB-style register file for gains and reverse action.
// Depends on ipid_pkg.
module ipid_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ipid_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output ipid_pkg::cfg_t               cfg
);
  import ipid_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_PROP_GAIN:  cfg_nxt.prop_gain      = pwdata[15:0];
        REG_INTEG_GAIN: cfg_nxt.integ_gain     = pwdata[15:0];
        REG_DERIV_GAIN: cfg_nxt.deriv_gain     = pwdata[15:0];
        REG_REVERSE:    cfg_nxt.reverse_action = pwdata[0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PROP_GAIN:  prdata = {16'd0, cfg_r.prop_gain};
      REG_INTEG_GAIN: prdata = {16'd0, cfg_r.integ_gain};
      REG_DERIV_GAIN: prdata = {16'd0, cfg_r.deriv_gain};
      REG_REVERSE:    prdata = {31'd0, cfg_r.reverse_action};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain      <= PROP_GAIN_RST;
      cfg_r.integ_gain     <= INTEG_GAIN_RST;
      cfg_r.deriv_gain     <= DERIV_GAIN_RST;
      cfg_r.reverse_action <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hw/rtl/ipid_core.sv @@
// PID datapath: error history, three gain products, saturation and drive accumulator.
// Depends on ipid_pkg and the assertion macro header.
`include "incremental_pid_controller_top_macros.svh"

module ipid_core #(
  parameter int FRAC_BITS = ipid_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  ipid_pkg::in_req_t  req,
  input  ipid_pkg::cfg_t     cfg,
  output ipid_pkg::out_rsp_t rsp
);
  import ipid_pkg::*;

  localparam int DW = (FRAC_BITS + 10 > 17) ? FRAC_BITS + 10 : 17;
  localparam logic signed [DW-1:0]    INC_LIM   = DW'(LIM_INC_UNITS * (2 ** FRAC_BITS));
  localparam logic signed [DW-1:0]    POS_LIM   = DW'(LIM_POS_UNITS * (2 ** FRAC_BITS));
  localparam logic signed [SUM_W-1:0] INC_LIM_S = SUM_W'(LIM_INC_UNITS * (2 ** FRAC_BITS));

  logic signed [ERR_W-1:0]  last_err_r, last_err_nxt, older_err_r, older_err_nxt;
  logic signed [ERR_W-1:0]  e1, e2, err;
  logic [1:0]               steps_r, steps_nxt, steps;
  logic signed [DW-1:0]     accum_r, accum_nxt;
  logic signed [DW-1:0]     pos_ext, pos_clamp, change, change_app, base, acc_sum, acc_clamp;
  logic signed [DIFF_W-1:0] p_op, i_op, d_op;
  logic signed [PROD_W-1:0] prod_p, prod_i, prod_d;
  logic signed [SUM_W-1:0]  sum, shifted, sat;
  logic                     first;

  always_comb begin
    steps = req.clear_history ? STEPS_FIRST : steps_r;
    e1    = req.clear_history ? '0 : last_err_r;
    e2    = req.clear_history ? '0 : older_err_r;
    err   = ERR_W'(req.setpoint) - ERR_W'(req.measured);
    first = (steps == STEPS_FIRST);

    // first step: P on e alone; D only once two errors are held
    p_op = first ? DIFF_W'(err) : DIFF_W'(err) - DIFF_W'(e1);
    i_op = first ? '0 : DIFF_W'(err);
    d_op = (steps == STEPS_LATER) ?
           DIFF_W'(err) - (DIFF_W'(e1) <<< 1) + DIFF_W'(e2) : '0;

    prod_p = PROD_W'(cfg.prop_gain)  * PROD_W'(p_op);
    prod_i = PROD_W'(cfg.integ_gain) * PROD_W'(i_op);
    prod_d = PROD_W'(cfg.deriv_gain) * PROD_W'(d_op);

    sum     = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
    shifted = sum >>> FRAC_BITS;
    if (shifted > INC_LIM_S) begin
      sat = INC_LIM_S;
    end else if (shifted < -INC_LIM_S) begin
      sat = -INC_LIM_S;
    end else begin
      sat = shifted;
    end
    change     = DW'(sat);
    change_app = cfg.reverse_action ? -change : change;

    pos_ext = DW'(req.manual_position);
    if (pos_ext > INC_LIM) begin
      pos_clamp = INC_LIM;
    end else if (pos_ext < -INC_LIM) begin
      pos_clamp = -INC_LIM;
    end else begin
      pos_clamp = pos_ext;
    end

    base    = first ? pos_clamp : accum_r;
    acc_sum = base + change_app;
    if (acc_sum > POS_LIM) begin
      acc_clamp = POS_LIM;
    end else if (acc_sum < -POS_LIM) begin
      acc_clamp = -POS_LIM;
    end else begin
      acc_clamp = acc_sum;
    end

    if (req.auto_mode) begin
      accum_nxt       = acc_clamp;
      older_err_nxt   = e1;
      last_err_nxt    = err;
      steps_nxt       = (steps == STEPS_FIRST) ? STEPS_SECOND : STEPS_LATER;
      rsp.step_change = change_app[15:0];
    end else begin
      accum_nxt       = pos_clamp;
      older_err_nxt   = '0;
      last_err_nxt    = '0;
      steps_nxt       = STEPS_FIRST;
      rsp.step_change = '0;
    end
    rsp.drive = accum_nxt[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r  <= '0;
      older_err_r <= '0;
      accum_r     <= '0;
      steps_r     <= STEPS_FIRST;
    end else if (step_en) begin
      last_err_r  <= last_err_nxt;
      older_err_r <= older_err_nxt;
      accum_r     <= accum_nxt;
      steps_r     <= steps_nxt;
    end
  end

  `ASSERT_ALWAYS(a_steps_sat, clk, rst_n, steps_r != 2'd3)
  `ASSERT_ALWAYS(a_accum_range, clk, rst_n, (accum_r <= INC_LIM) && (accum_r >= -INC_LIM))
  `ASSERT_NEXT(a_manual_clears, clk, rst_n, step_en && !req.auto_mode, (steps_r == STEPS_FIRST) && (last_err_r == '0) && (older_err_r == '0))
  `ASSERT_NEXT(a_no_step_hold, clk, rst_n, !step_en, $stable(accum_r) && $stable(steps_r))

endmodule

@@ hw/rtl/incremental_pid_controller_top.sv @@
// Top level of the velocity-form PID controller: sample register, result register.
// Depends on ipid_pkg, ipid_regs, ipid_core and the assertion macro header.
//
//   channel  dir  handshake               payload
//   in_      in   in_valid / in_stall     in_data  (ipid_pkg::in_req_t)
//   out_     out  out_valid / out_stall   out_data (ipid_pkg::out_rsp_t)
//   apb      in   psel/penable/pwrite     paddr, pwdata -> prdata, pready
//
// One sample per cycle unless out_stall holds a valid result. The combinational path is
// sample register -> three multiplies -> sum, clamp, accumulate -> result register; the
// controller history updates as the result loads.
// Synchronous active-low reset clears gains to defaults, history and both valid flags.
// out_stall holds a valid result register; a held sample then stalls the input.
`include "incremental_pid_controller_top_macros.svh"

module incremental_pid_controller_top #(
  parameter int FRAC_BITS = ipid_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  ipid_pkg::in_req_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output ipid_pkg::out_rsp_t           out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ipid_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import ipid_pkg::*;

  in_req_t  s1_req_r;
  logic     s1_valid_r, s1_valid_nxt;
  out_rsp_t out_data_r;
  logic     out_valid_r, out_valid_nxt;
  out_rsp_t core_rsp;
  cfg_t     cfg;
  logic     advance;
  logic     in_take;

  ipid_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ipid_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .req     (s1_req_r),
    .cfg     (cfg),
    .rsp     (core_rsp)
  );

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r <= in_data;
    end
    if (advance) begin
      out_data_r <= core_rsp;
    end
  end

  `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, in_stall, s1_valid_r && out_valid_r && out_stall)
  `ASSERT_NEXT(a_take_loads, clk, rst_n, in_take, s1_valid_r)
  `ASSERT_NEXT(a_advance_out, clk, rst_n, advance, out_valid_r)
  `ASSERT_NEXT(a_drain, clk, rst_n, out_valid_r && !out_stall && !s1_valid_r, !out_valid_r)

endmodule
